### rtl/lpht_pkg.sv
// Shared types and constants for the linear-probing hash table unit.
package lpht_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int COUNT_W     = SLOT_W + 1;
    localparam int CFG_W       = 9;
    localparam int LIMIT_W     = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 9'd192;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic        operation;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [31:0] item_value;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_value;
    } t_result;

    // A request after classification, as held in the queue.
    typedef struct packed {
        logic              operation;
        logic [31:0]       key_id;
        logic [31:0]       item_value;
        logic [SLOT_W-1:0] start_slot;
    } t_job;

endpackage

### rtl/linear_probe_hash_table_unit.sv
// Top level of the linear-probing hash table unit.
//
// Requests (lookup or insert) enter on i_req and are taken at a clock edge where
// start is high and busy is low. Each request gives exactly one result on
// o_result, shown for one cycle with o_done high; the receiver cannot stall.
// Results come out in request order.
// A two-entry queue sits between the accepting front end and the probe engine,
// so busy rises only when that queue is full.
// The probe engine picks up a request in its idle state, then passes through a
// read state (valid check and memory read) and a check state (key compare) for
// each occupied slot; an empty slot ends a run in the read state, and a run
// through a full table without a match ends after the last slot. A lookup in an
// empty table answers from the idle state; the probe run length sets the
// throughput. The load limit is written through i_cfg_we / i_cfg_wdata; the
// user must write it only while the unit is idle, as the block itself does not
// enforce it. Reset clears the valid marks, the entry count and the queue and
// sets the limit to 192; the slot memories are not cleared.
module linear_probe_hash_table_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  lpht_pkg::t_request          i_req,
    output logic                        busy,
    output logic                        o_done,
    output lpht_pkg::t_result           o_result,
    input  logic                        i_cfg_we,
    input  logic [lpht_pkg::CFG_W-1:0]  i_cfg_wdata
);

    logic           job_valid;
    logic           job_pop;
    lpht_pkg::t_job job;

    lpht_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_pop       (job_pop),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    lpht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (job_pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

### rtl/lpht_front.sv
// Front end: accepts requests, works out the home slot and queues them.
module lpht_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  lpht_pkg::t_request i_req,
    output logic              busy,
    input  logic              i_pop,
    output logic              o_job_valid,
    output lpht_pkg::t_job    o_job
);

    lpht_pkg::t_job r_queue [lpht_pkg::QUEUE_DEPTH];
    logic [lpht_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [lpht_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [lpht_pkg::FILL_W-1:0]   r_fill;
    lpht_pkg::t_job                new_job;
    logic                          push;
    logic                          pop;

    always_comb begin
        new_job.operation  = i_req.operation;
        new_job.key_id     = i_req.key_id;
        new_job.item_value = i_req.item_value;
        // The table size is a power of two, so the home slot is the low hash bits.
        new_job.start_slot = i_req.key_hash[lpht_pkg::SLOT_W-1:0];
    end

    assign busy        = (r_fill == lpht_pkg::FILL_W'(lpht_pkg::QUEUE_DEPTH));
    assign push        = start && !busy;
    assign o_job_valid = (r_fill != '0);
    assign pop         = i_pop && o_job_valid;
    assign o_job       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= lpht_pkg::FILL_W'(lpht_pkg::QUEUE_DEPTH))
        else $error("queue fill above its depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

endmodule

### rtl/lpht_back.sv
// Back end: probe engine with the slot memories, valid marks and entry count.
module lpht_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lpht_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_job_valid,
    input  lpht_pkg::t_job               i_job,
    output logic                         o_pop,
    output logic                         o_done,
    output lpht_pkg::t_result            o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK
    } t_state;

    t_state                            r_state;
    logic [31:0]                       mem_keys   [lpht_pkg::TABLE_SLOTS];
    logic [31:0]                       mem_values [lpht_pkg::TABLE_SLOTS];
    logic [31:0]                       r_rd_key;
    logic [31:0]                       r_rd_value;
    logic [lpht_pkg::TABLE_SLOTS-1:0]  r_valid;
    logic [lpht_pkg::COUNT_W-1:0]      r_count;
    logic [lpht_pkg::CFG_W-1:0]        r_max_entries;
    logic [lpht_pkg::SLOT_W-1:0]       r_idx;
    logic [lpht_pkg::SLOT_W-1:0]       r_probe_n;
    logic                              r_op;
    logic [31:0]                       r_key;
    logic [31:0]                       r_value;
    logic                              r_done;
    lpht_pkg::t_result                 r_result;

    logic [lpht_pkg::LIMIT_W-1:0]      cfg_ext;
    logic [lpht_pkg::LIMIT_W-1:0]      eff_limit;
    logic [lpht_pkg::LIMIT_W-1:0]      count_next;
    logic                              limit_hit;
    logic                              slot_empty;
    logic                              mem_we;
    logic                              last_probe;

    assign o_pop    = (r_state == S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // A limit above the table size behaves as the table size.
    assign cfg_ext    = lpht_pkg::LIMIT_W'(r_max_entries);
    assign eff_limit  = (cfg_ext > lpht_pkg::LIMIT_W'(lpht_pkg::TABLE_SLOTS))
                        ? lpht_pkg::LIMIT_W'(lpht_pkg::TABLE_SLOTS) : cfg_ext;
    assign count_next = lpht_pkg::LIMIT_W'(r_count) + lpht_pkg::LIMIT_W'(1);
    assign limit_hit  = (count_next > eff_limit);
    assign slot_empty = !r_valid[r_idx];
    assign mem_we     = (r_state == S_READ) && slot_empty
                        && (r_op == lpht_pkg::OP_INSERT) && !limit_hit;
    assign last_probe = (r_probe_n == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_keys[r_idx]   <= r_key;
            mem_values[r_idx] <= r_value;
        end
        r_rd_key   <= mem_keys[r_idx];
        r_rd_value <= mem_values[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_count       <= '0;
            r_max_entries <= lpht_pkg::MAX_ENTRIES_RESET;
            r_done        <= 1'b0;
            r_result      <= '{status: lpht_pkg::ST_OK, found_value: '0};
            r_idx         <= '0;
            r_probe_n     <= '0;
            r_op          <= lpht_pkg::OP_LOOKUP;
            r_key         <= '0;
            r_value       <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_op      <= i_job.operation;
                        r_key     <= i_job.key_id;
                        r_value   <= i_job.item_value;
                        r_idx     <= i_job.start_slot;
                        r_probe_n <= '0;
                        // A lookup in an empty table needs no probe at all.
                        if (i_job.operation == lpht_pkg::OP_LOOKUP && r_count == '0) begin
                            r_done   <= 1'b1;
                            r_result <= '{status: lpht_pkg::ST_NOT_FOUND, found_value: '0};
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (slot_empty) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_op == lpht_pkg::OP_LOOKUP) begin
                            r_result <= '{status: lpht_pkg::ST_NOT_FOUND, found_value: '0};
                        end else if (limit_hit) begin
                            r_result <= '{status: lpht_pkg::ST_FULL, found_value: '0};
                        end else begin
                            r_valid[r_idx] <= 1'b1;
                            r_count        <= r_count + 1'b1;
                            r_result       <= '{status: lpht_pkg::ST_OK, found_value: '0};
                        end
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_rd_key == r_key) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_op == lpht_pkg::OP_LOOKUP) begin
                            r_result <= '{status: lpht_pkg::ST_OK, found_value: r_rd_value};
                        end else begin
                            r_result <= '{status: lpht_pkg::ST_DUPLICATE, found_value: '0};
                        end
                    end else if (last_probe) begin
                        // Every slot is taken and none holds the key.
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_op == lpht_pkg::OP_LOOKUP) begin
                            r_result <= '{status: lpht_pkg::ST_NOT_FOUND, found_value: '0};
                        end else begin
                            r_result <= '{status: lpht_pkg::ST_FULL, found_value: '0};
                        end
                    end else begin
                        r_idx     <= r_idx + 1'b1;
                        r_probe_n <= r_probe_n + 1'b1;
                        r_state   <= S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lpht_pkg::COUNT_W'(lpht_pkg::TABLE_SLOTS))
        else $error("entry count above table size");

    a_count_with_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_done && r_result.status == lpht_pkg::ST_OK
                    && r_count == $past(r_count) + 1'b1))
        else $error("insert did not report ok with the count raised");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.status != lpht_pkg::ST_OK) |-> (r_result.found_value == '0))
        else $error("value reported on a failed request");

endmodule

### tb/lpht_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the hash table unit: a table model that predicts each result, and its checker.
package lpht_scoreboard_pkg;
    import lpht_pkg::*;

    // How a probe run ended.
    localparam int PROBE_HIT   = 0;
    localparam int PROBE_EMPTY = 1;
    localparam int PROBE_NONE  = 2;

    class lpht_scoreboard;
        logic [31:0]      slot_key  [TABLE_SLOTS];
        logic [31:0]      slot_val  [TABLE_SLOTS];
        bit               slot_used [TABLE_SLOTS];
        int unsigned      entries;
        logic [CFG_W-1:0] load_limit;
        t_result          awaited [$];
        int unsigned      mismatches;
        int unsigned      requests;
        int unsigned      status_seen [4];

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_val[i]  = '0;
            end
            foreach (status_seen[i]) status_seen[i] = 0;
            entries    = 0;
            load_limit = MAX_ENTRIES_RESET;
            mismatches = 0;
            requests   = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function bit holds(logic [31:0] key);
            foreach (slot_used[i]) begin
                if (slot_used[i] && slot_key[i] == key) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Walk upward from the home slot until the key or an empty slot turns up.
        function int find_slot(logic [31:0] key, logic [31:0] hash, output int slot);
            int idx;
            idx  = int'(hash[SLOT_W-1:0]);
            slot = 0;
            for (int n = 0; n < TABLE_SLOTS; n++) begin
                if (!slot_used[idx]) begin
                    slot = idx;
                    return PROBE_EMPTY;
                end
                if (slot_key[idx] == key) begin
                    slot = idx;
                    return PROBE_HIT;
                end
                idx = (idx + 1) % TABLE_SLOTS;
            end
            return PROBE_NONE;
        endfunction

        function void note_request(t_request req);
            t_result     res;
            int          slot;
            int          outcome;
            int unsigned cap;
            res.status      = ST_NOT_FOUND;
            res.found_value = '0;
            requests++;
            if (req.operation == OP_LOOKUP) begin
                if (entries != 0) begin
                    outcome = find_slot(req.key_id, req.key_hash, slot);
                    if (outcome == PROBE_HIT) begin
                        res.status      = ST_OK;
                        res.found_value = slot_val[slot];
                    end
                end
            end else begin
                // A limit above the table size behaves as the table size.
                cap     = (load_limit > TABLE_SLOTS) ? TABLE_SLOTS : load_limit;
                outcome = find_slot(req.key_id, req.key_hash, slot);
                if (outcome == PROBE_HIT) begin
                    res.status = ST_DUPLICATE;
                end else if (outcome == PROBE_NONE || entries + 1 > cap) begin
                    res.status = ST_FULL;
                end else begin
                    slot_key[slot]  = req.key_id;
                    slot_val[slot]  = req.item_value;
                    slot_used[slot] = 1'b1;
                    entries++;
                    res.status = ST_OK;
                end
            end
            awaited.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding: status %0d, found_value %h",
                       got.status, got.found_value);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.found_value !== want.found_value) begin
                $error("found_value mismatch: expected %h, actual %h",
                       want.found_value, got.found_value);
                mismatches++;
            end
        endfunction
    endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the hash table unit: clock, reset, stimulus and result monitor.
module tb_top;
    import lpht_pkg::*;
    import lpht_scoreboard_pkg::*;

    localparam int POOL_SIZE    = 384;
    localparam int DRAIN_CYCLES = 4 * TABLE_SLOTS + 16;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    t_request         i_req       = '0;
    logic             busy;
    logic             o_done;
    t_result          o_result;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    int unsigned      idle_pct = 0;
    logic [31:0]      pool_key  [POOL_SIZE];
    logic [31:0]      pool_hash [POOL_SIZE];
    lpht_scoreboard   sb = new();

    linear_probe_hash_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Inputs change only through nonblocking updates, so these reads see pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_request(i_req);
            if (o_done) sb.check_result(o_result);
        end
    end

    function automatic t_request make_request(logic op, logic [31:0] key,
                                              logic [31:0] hash, logic [31:0] value);
        t_request req;
        req.operation  = op;
        req.key_id     = key;
        req.key_hash   = hash;
        req.item_value = value;
        return req;
    endfunction

    function automatic t_request noise_request();
        return make_request($urandom_range(1) ? OP_INSERT : OP_LOOKUP,
                            $urandom(), $urandom(), $urandom());
    endfunction

    // Mostly keys from the pool with their own hash, so lookups hit and inserts collide.
    function automatic t_request random_request();
        int          pick;
        int          idx;
        logic [31:0] key;
        logic [31:0] hash;
        pick = $urandom_range(99);
        idx  = $urandom_range(POOL_SIZE - 1);
        if (pick < 85) begin
            key  = pool_key[idx];
            hash = (pick < 78) ? pool_hash[idx] : $urandom();
        end else begin
            key  = $urandom();
            hash = $urandom();
        end
        return make_request($urandom_range(1) ? OP_INSERT : OP_LOOKUP, key, hash, $urandom());
    endfunction

    function automatic logic [31:0] fresh_key();
        logic [31:0] key;
        key = $urandom();
        while (sb.holds(key)) key = $urandom();
        return key;
    endfunction

    task automatic send_item(input t_request req);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_req <= noise_request();
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= CFG_W'($urandom());
        sb.load_limit = value;
    endtask

    task automatic run_random(input int count, input int unsigned pct);
        idle_pct = pct;
        repeat (count) send_item(random_request());
    endtask

    initial begin
        int          slot;
        logic [31:0] hash;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_key[i]  = {23'($urandom() >> 9), 9'(i)};
            pool_hash[i] = $urandom();
            // Some keys share home slots around the wrap point to build long clusters.
            if ($urandom_range(99) < 12) pool_hash[i][7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lookups on the empty table.
        idle_pct = 0;
        send_item(make_request(OP_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF));
        send_item(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));

        // With a zero limit every new key is refused.
        write_limit(9'd0);
        send_item(make_request(OP_INSERT, 32'h0000_1234, 32'h0, 32'h1));

        // Two keys in the last slot and, by wrapping, the first; then the limit is reached.
        write_limit(9'd2);
        send_item(make_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
        send_item(make_request(OP_INSERT, 32'h0, 32'h0000_00FF, 32'hFFFF_FFFF));
        send_item(make_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5));
        send_item(make_request(OP_INSERT, 32'h0, 32'h0000_00FF, 32'h6));
        send_item(make_request(OP_INSERT, 32'hA5A5_A5A5, 32'h0000_0010, 32'h7));
        send_item(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
        send_item(make_request(OP_LOOKUP, 32'h0, 32'h0000_00FF, 32'h0));
        send_item(make_request(OP_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF));
        send_item(make_request(OP_LOOKUP, 32'h5A5A_5A5A, 32'h0000_00FF, 32'h0));

        // Limit lowered below the count: lookups still answer, new keys are full.
        write_limit(9'd1);
        send_item(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
        send_item(make_request(OP_INSERT, 32'h0000_0001, 32'h0000_0080, 32'h8));
        send_item(make_request(OP_INSERT, 32'h0, 32'h0000_00FF, 32'h9));

        write_limit(9'd64);
        run_random(300, 0);
        write_limit(9'd128);
        run_random(300, 65);
        write_limit(9'd100);
        run_random(200, 19);
        write_limit(MAX_ENTRIES_RESET);
        run_random(350, 0);
        run_random(350, 65);

        // Fill the whole table, then probe it with no empty slot left.
        write_limit(9'd256);
        idle_pct = 19;
        while (sb.entries < TABLE_SLOTS - 24)
            send_item(make_request(OP_INSERT, fresh_key(), $urandom(), $urandom()));
        write_limit(9'h1FF);
        idle_pct = 65;
        while (sb.entries < TABLE_SLOTS)
            send_item(make_request(OP_INSERT, fresh_key(), $urandom(), $urandom()));
        drain();
        repeat (6) send_item(make_request(OP_LOOKUP, fresh_key(), $urandom(), $urandom()));
        repeat (6) begin
            slot = $urandom_range(TABLE_SLOTS - 1);
            hash = ($urandom() & ~32'(TABLE_SLOTS - 1)) | 32'(slot);
            send_item(make_request(OP_LOOKUP, sb.slot_key[slot], hash, $urandom()));
        end
        repeat (2) send_item(make_request(OP_INSERT, fresh_key(), $urandom(), $urandom()));
        repeat (2) begin
            slot = $urandom_range(TABLE_SLOTS - 1);
            hash = ($urandom() & ~32'(TABLE_SLOTS - 1)) | 32'(slot);
            send_item(make_request(OP_INSERT, sb.slot_key[slot], hash, $urandom()));
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d requests: %0d ok, %0d not found, %0d duplicate, %0d full.",
                 sb.requests, sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
                 sb.status_seen[ST_DUPLICATE], sb.status_seen[ST_FULL]);
        $display("Load limits from 0 to 511 were used; the table ended with %0d of %0d slots.",
                 sb.entries, TABLE_SLOTS);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
